// ===== rtl/b26_pkg.sv =====
// ---------------------------------------------------------------------------
// b26_pkg
// Shared types and constants for the base-26 string to integer converter.
// ---------------------------------------------------------------------------
`default_nettype none

package b26_pkg;

  // Character codes
  localparam logic [7:0] CH_UP_A = 8'h41;  // 'A'
  localparam logic [7:0] CH_UP_Z = 8'h5A;  // 'Z'
  localparam logic [7:0] CH_LO_A = 8'h61;  // 'a'
  localparam logic [7:0] CH_LO_Z = 8'h7A;  // 'z'
  localparam logic [7:0] CH_MINUS = 8'h2D; // '-'
  localparam logic [7:0] CH_PLUS = 8'h2B;  // '+'

  // Digit limits
  localparam logic [3:0] DIG_MAX_NARROW = 4'd7;
  localparam logic [3:0] DIG_MAX_WIDE = 4'd14;
  localparam logic [3:0] DIG_CNT_SAT = 4'hF;

  // Range limits
  localparam logic [63:0] LIM_S32 = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] LIM_U32 = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] LIM_S64 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LIM_U64 = 64'hFFFF_FFFF_FFFF_FFFF;

  // Place weight saturates once another x26 would wrap
  localparam logic [63:0] PW_SAT_THR = 64'hFFFF_FFFF_FFFF_FFFF / 64'd26;

  // Config register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MODE = 2'd1;

  // Queue between classifier and accumulator
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_INVALID = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PH_TRAIL = 2'd0,
    PH_DIGITS = 2'd1,
    PH_LEAD = 2'd2,
    PH_DONE = 2'd3
  } phase_e;

  // Classified character word
  typedef struct packed {
    logic       start;
    logic       blank;
    logic       minus;
    logic       plus;
    logic       upper;
    logic       lower;
    logic [4:0] off;    // letter offset from 'A' or 'a'
  } cls_t;

  typedef struct packed {
    logic wide;
    logic sgn;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/base26_string_to_integer_core.sv =====
// ---------------------------------------------------------------------------
// base26_string_to_integer_core
// Converts a base-26 letter string, fed last byte first, into an integer.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o): one string byte per word with
//   is_string_start_i marking the string's first byte. Bytes come last to
//   first. The start byte closes the conversion.
//   Output channel (out_valid_o/out_ready_i): one word per string, value_o
//   and status_o (0 ok, 1 invalid, 2 overflow). value_o is zero unless ok.
//   Config channel (cfg_valid_i/cfg_ready_o): index 0 wide_mode, index 1
//   signed_mode, data in cfg_data_i; always ready. Write only when idle.
// Timing:
//   Throughput is one byte per cycle unless a held result stalls a start byte,
//   set by the accumulator's multiply-accumulate and range compare on the magnitude register.
//   The result word is registered when the start byte, after passing the queue, is popped.
// Reset:
//   Queue empty, parser in trailing-blank phase, wide_mode=0,
//   signed_mode=1. Ready right after reset.
// Stall:
//   A held result blocks only the next start byte; other bytes keep
//   flowing through the 2-entry queue until it fills and in_ready_o drops.
// ---------------------------------------------------------------------------
`default_nettype none

module base26_string_to_integer_core import b26_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // config write port
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic                 cfg_data_i,
  // byte input
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [7:0]           char_in_i,
  input  wire logic                 is_string_start_i,
  // result output
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [63:0]               value_o,
  output logic [1:0]                status_o
);

  cfg_t cfg_q, cfg_d;
  logic q_push, q_full, q_pop, q_valid;
  cls_t q_wdata, q_rdata;

  assign cfg_ready_o = 1'b1;

  // config registers; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_WIDE_MODE:   cfg_d.wide = cfg_data_i;
        CFG_SIGNED_MODE: cfg_d.sgn  = cfg_data_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wide <= 1'b0;
      cfg_q.sgn  <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front: accept and classify
  b26_front u_front (
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .char_in_i         (char_in_i),
    .is_string_start_i (is_string_start_i),
    .q_full_i          (q_full),
    .q_push_o          (q_push),
    .q_wdata_o         (q_wdata)
  );

  // decoupling queue
  b26_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  // back: parse, accumulate, hold result
  b26_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_rdata_i   (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o),
    .status_o    (status_o)
  );

endmodule

`default_nettype wire

// ===== rtl/b26_front.sv =====
// ---------------------------------------------------------------------------
// b26_front
// Input side: accepts string bytes and classifies each one.
// ---------------------------------------------------------------------------
`default_nettype none

module b26_front import b26_pkg::*; (
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] char_in_i,
  input  wire logic       is_string_start_i,
  input  wire logic       q_full_i,
  output logic            q_push_o,
  output cls_t            q_wdata_o
);

  logic [7:0] up_diff;
  logic [7:0] lo_diff;
  logic       is_up;

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  assign up_diff = char_in_i - CH_UP_A;
  assign lo_diff = char_in_i - CH_LO_A;
  assign is_up   = char_in_i inside {[CH_UP_A:CH_UP_Z]};

  always_comb begin
    q_wdata_o.start = is_string_start_i;
    q_wdata_o.blank = char_in_i inside {8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0B, 8'h0C};
    q_wdata_o.minus = (char_in_i == CH_MINUS);
    q_wdata_o.plus  = (char_in_i == CH_PLUS);
    q_wdata_o.upper = is_up;
    q_wdata_o.lower = char_in_i inside {[CH_LO_A:CH_LO_Z]};
    q_wdata_o.off   = is_up ? up_diff[4:0] : lo_diff[4:0];
  end

endmodule

`default_nettype wire

// ===== rtl/b26_queue.sv =====
// ---------------------------------------------------------------------------
// b26_queue
// Short FIFO of classified words between classifier and accumulator.
// ---------------------------------------------------------------------------
`default_nettype none

module b26_queue import b26_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cls_t      wdata_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output cls_t      rdata_o
);

  cls_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // pointer wrap works for any depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/b26_back.sv =====
// ---------------------------------------------------------------------------
// b26_back
// Accumulator: runs the parse state machine, base-26 multiply-accumulate,
// range checks, and holds the result word until it is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module b26_back import b26_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  cfg_t             cfg_i,
  input  wire logic        q_valid_i,
  input  cls_t             q_rdata_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      value_o,
  output logic [1:0]       status_o
);

  phase_e      phase_q, phase_d, step_phase, dig_phase;
  logic        upper_q, upper_d;
  logic [3:0]  cnt_q, cnt_d, cnt_inc, dig_cnt, maxdig;
  logic [63:0] mag_q, mag_d, dig_mag;
  logic [63:0] pw_q, pw_d, dig_pw, pw_next, pw_mul;
  status_e     err_q, err_d, dig_err, step_err, res_status;
  logic        neg_q, neg_d, dig_neg, step_neg;
  logic        step_upper;
  logic [3:0]  step_cnt;
  logic [63:0] step_mag, step_pw;

  logic        out_valid_q, out_valid_d;
  logic [63:0] out_mag_q, out_mag_d;
  logic        out_neg_q, out_neg_d;
  logic        out_wide_q, out_wide_d;
  status_e     out_status_q, out_status_d;

  cls_t        w;
  logic        up_eff, digit_ok, d_nz, range_ovf, take;
  logic [63:0] lim;
  logic [68:0] prod;
  logic [69:0] sum;
  logic [63:0] neg_val;

  assign w = q_rdata_i;

  // a start word needs the result slot free or draining
  assign q_pop_o = q_valid_i && (!w.start || !out_valid_q || out_ready_i);

  always_comb begin
    case ({cfg_i.wide, cfg_i.sgn})
      2'b11:   lim = LIM_S64;
      2'b10:   lim = LIM_U64;
      2'b01:   lim = LIM_S32;
      default: lim = LIM_U32;
    endcase
  end

  assign maxdig   = cfg_i.wide ? DIG_MAX_WIDE : DIG_MAX_NARROW;
  assign up_eff   = (phase_q == PH_TRAIL) ? w.upper : upper_q;
  assign digit_ok = up_eff ? w.upper : w.lower;
  assign cnt_inc  = (cnt_q == DIG_CNT_SAT) ? cnt_q : cnt_q + 1'b1;
  assign d_nz     = (w.off != '0);
  assign prod     = 69'(pw_q) * 69'(w.off);
  assign sum      = 70'(mag_q) + 70'(prod);
  assign range_ovf = (mag_q > lim) || (pw_q > lim) || (sum > 70'(lim));
  assign pw_mul   = (pw_q << 4) + (pw_q << 3) + (pw_q << 1);
  assign pw_next  = (pw_q > PW_SAT_THR) ? '1 : pw_mul;
  assign take     = ((phase_q == PH_TRAIL) && !w.blank) || (phase_q == PH_DIGITS);

  // digit byte handling
  always_comb begin
    dig_phase = PH_DIGITS;
    dig_err   = err_q;
    dig_neg   = neg_q;
    dig_mag   = mag_q;
    dig_pw    = pw_q;
    dig_cnt   = cnt_q;
    if (w.minus) begin
      dig_neg   = 1'b1;
      dig_phase = PH_DONE;
    end else if (w.plus) begin
      dig_phase = PH_DONE;
    end else if (w.blank) begin
      dig_phase = PH_LEAD;
    end else if (!digit_ok) begin
      dig_err   = ST_INVALID;
      dig_phase = PH_DONE;
    end else begin
      dig_cnt = cnt_inc;
      if ((cnt_inc > maxdig) && d_nz) begin
        dig_err   = ST_OVERFLOW;
        dig_phase = PH_DONE;
      end else if (d_nz && range_ovf) begin
        dig_err   = ST_OVERFLOW;
        dig_phase = PH_DONE;
      end else begin
        dig_mag = sum[63:0];
        dig_pw  = pw_next;
      end
    end
  end

  // next state
  always_comb begin
    step_phase = phase_q;
    case (phase_q)
      PH_TRAIL:  if (!w.blank) step_phase = dig_phase;
      PH_DIGITS: step_phase = dig_phase;
      PH_LEAD:   if (!w.blank) step_phase = PH_DONE;
      PH_DONE:   step_phase = PH_DONE;
      default:   step_phase = phase_q;
    endcase
    phase_d = phase_q;
    if (q_pop_o) begin
      phase_d = w.start ? PH_TRAIL : step_phase;
    end
  end

  // datapath and result
  always_comb begin
    step_upper = (phase_q == PH_TRAIL && !w.blank) ? w.upper : upper_q;
    step_cnt   = take ? dig_cnt : cnt_q;
    step_mag   = take ? dig_mag : mag_q;
    step_pw    = take ? dig_pw : pw_q;
    step_err   = take ? dig_err : err_q;
    step_neg   = take ? dig_neg : neg_q;
    if ((phase_q == PH_LEAD) && !w.blank && w.minus) begin
      step_neg = 1'b1;
    end

    upper_d = upper_q;
    cnt_d   = cnt_q;
    mag_d   = mag_q;
    pw_d    = pw_q;
    err_d   = err_q;
    neg_d   = neg_q;
    if (q_pop_o) begin
      if (w.start) begin
        upper_d = 1'b0;
        cnt_d   = '0;
        mag_d   = '0;
        pw_d    = 64'd1;
        err_d   = ST_OK;
        neg_d   = 1'b0;
      end else begin
        upper_d = step_upper;
        cnt_d   = step_cnt;
        mag_d   = step_mag;
        pw_d    = step_pw;
        err_d   = step_err;
        neg_d   = step_neg;
      end
    end

    res_status   = (step_phase == PH_TRAIL) ? ST_INVALID : step_err;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_mag_d    = out_mag_q;
    out_neg_d    = out_neg_q;
    out_wide_d   = out_wide_q;
    out_status_d = out_status_q;
    if (q_pop_o && w.start) begin
      out_valid_d  = 1'b1;
      out_mag_d    = (res_status == ST_OK) ? step_mag : '0;
      out_neg_d    = step_neg;
      out_wide_d   = cfg_i.wide;
      out_status_d = res_status;
    end
  end

  // negate on the held word, keeps it off the accumulate path
  assign neg_val     = out_neg_q ? (64'd0 - out_mag_q) : out_mag_q;
  assign value_o     = out_wide_q ? neg_val : {32'd0, neg_val[31:0]};
  assign status_o    = out_status_q;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_TRAIL;
      upper_q     <= 1'b0;
      cnt_q       <= '0;
      mag_q       <= '0;
      pw_q        <= 64'd1;
      err_q       <= ST_OK;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      upper_q     <= upper_d;
      cnt_q       <= cnt_d;
      mag_q       <= mag_d;
      pw_q        <= pw_d;
      err_q       <= err_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_mag_q    <= out_mag_d;
    out_neg_q    <= out_neg_d;
    out_wide_q   <= out_wide_d;
    out_status_q <= out_status_d;
  end

endmodule

`default_nettype wire
